// ----- hdl/cbz_pkg.sv -----
// ----------------------------------------------------------------------------
// Cubic Bezier sampler package
// Shared constants, beat payload types, controller states and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cbz_pkg;

    // Design constants.
    localparam int MAX_POINTS  = 64;
    localparam int COORD_BITS  = 12;
    localparam int T_FRAC_BITS = 16;
    localparam int CNT_BITS    = 7;

    // Derived widths.
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int D_W    = $clog2(MAX_POINTS);
    localparam int T_W    = T_FRAC_BITS + 1;
    localparam int COEF_W = COORD_BITS + 4;
    localparam int ACC_W  = COORD_BITS + 5 + T_FRAC_BITS;
    localparam int PROD_W = ACC_W + T_W + 1;
    localparam int INT_W  = ACC_W - T_FRAC_BITS;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] ctrl1_x;
        logic [COORD_BITS-1:0] ctrl1_y;
        logic [COORD_BITS-1:0] ctrl2_x;
        logic [COORD_BITS-1:0] ctrl2_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic [CNT_BITS-1:0]   point_count;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] curve_x;
        logic [COORD_BITS-1:0] curve_y;
        logic                  last_point;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_INIT,
        S_MUL,
        S_ADD,
        S_EMIT
    } t_state;

    // Which coefficient the Horner add step folds in.
    typedef enum logic [1:0] {
        SEL_B,
        SEL_C,
        SEL_P0
    } t_coef_sel;

    typedef struct packed {
        logic      load;
        logic      div_start;
        logic      init;
        logic      mul;
        logic      add;
        logic      emit;
        logic      step;
        t_coef_sel sel;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic n_zero;
        logic n_one;
        logic last_pt;
    } t_stat;

endpackage

// ----- hdl/cubic_bezier_sampler.sv -----
// ----------------------------------------------------------------------------
// Cubic Bezier sampler
// Takes one cubic Bezier segment per beat and emits its sampled curve points.
// ----------------------------------------------------------------------------
// A segment beat is taken when start is high and busy is low. The block then
// emits point_count points (saturated to MAX_POINTS) at t = i/(count-1), one
// result beat per point, each on o_result for a single cycle with o_strobe
// high; the receiver cannot stall, so it must take every beat as it comes.
// The final point of a segment carries last_point. A count of zero emits
// nothing and a count of one emits the start point. For each segment the
// controller loads and classifies the count, then, for counts of two or
// more, runs the serial step divider (one quotient bit per cycle for the
// 17-bit t step), then seeds the Horner accumulators, then for each point
// runs the three Horner multiply-add steps through the per-axis multiplier,
// whose product is registered before each add, and registers the result
// beat. Results are truncated toward minus infinity and clamped to the
// pixel range.
module cubic_bezier_sampler
    import cbz_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    // Command and status groups between the sequencer and the datapath.
    t_cmd  cmd;
    t_stat stat;

    cbz_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // The datapath captures the segment on the load command, which the
    // controller raises only in its idle state, so a beat offered while busy
    // is simply not taken.
    cbz_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ----- hdl/cbz_div.sv -----
// ----------------------------------------------------------------------------
// Cubic Bezier sampler step divider
// Restoring divider, one quotient bit per cycle, forming the t step as
// 2^T_FRAC_BITS / d with its remainder.
// ----------------------------------------------------------------------------
module cbz_div
    import cbz_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [D_W-1:0] i_den,
    output logic [T_W-1:0] o_quo,
    output logic [D_W-1:0] o_rem,
    output logic           o_done
);

    localparam int CNT_W = $clog2(T_W + 1);

    logic             r_run;
    logic [CNT_W-1:0] r_cnt;
    logic [T_W-1:0]   r_num;
    logic [T_W-1:0]   r_quo;
    logic [D_W:0]     r_rem;

    logic [D_W:0]     shifted;
    logic             fits;

    assign shifted = {r_rem[D_W-1:0], r_num[T_W-1]};
    assign fits    = shifted >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= CNT_W'(T_W);
        end else if (r_run && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= T_ONE;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_run && r_cnt != '0) begin
            r_num <= {r_num[T_W-2:0], 1'b0};
            r_quo <= {r_quo[T_W-2:0], fits};
            r_rem <= fits ? (shifted - {1'b0, i_den}) : shifted;
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem[D_W-1:0];
    assign o_done = r_run && (r_cnt == '0);

endmodule

// ----- hdl/cbz_dpath.sv -----
// ----------------------------------------------------------------------------
// Cubic Bezier sampler datapath
// Coefficient registers, the t stepper, one Horner multiply-add unit per axis
// and the registered result beat.
// ----------------------------------------------------------------------------
module cbz_dpath
    import cbz_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic      o_strobe,
    output t_out_item o_result
);

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] p0;
    } t_coef;

    function automatic t_coef make_coef(input logic [COORD_BITS-1:0] p0,
                                        input logic [COORD_BITS-1:0] p1,
                                        input logic [COORD_BITS-1:0] p2,
                                        input logic [COORD_BITS-1:0] p3);
        logic signed [COEF_W-1:0] s0, s1, s2, s3, d10, d21;
        t_coef k;
        s0   = $signed(COEF_W'(p0));
        s1   = $signed(COEF_W'(p1));
        s2   = $signed(COEF_W'(p2));
        s3   = $signed(COEF_W'(p3));
        d10  = s1 - s0;
        d21  = s2 - s1;
        k.c  = (d10 <<< 1) + d10;
        k.b  = (d21 <<< 1) + d21 - k.c;
        k.a  = s3 - s0 - k.c - k.b;
        k.p0 = s0;
        return k;
    endfunction

    function automatic logic signed [ACC_W-1:0] to_acc(input logic signed [COEF_W-1:0] v);
        return ACC_W'(v) <<< T_FRAC_BITS;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_px(input logic signed [ACC_W-1:0] acc);
        logic signed [INT_W-1:0] ip;
        ip = acc[ACC_W-1:T_FRAC_BITS];
        if (ip[INT_W-1]) begin
            return '0;
        end else if (|ip[INT_W-2:COORD_BITS]) begin
            return '1;
        end
        return ip[COORD_BITS-1:0];
    endfunction

    t_coef                    r_coef [2];
    logic signed [ACC_W-1:0]  r_acc  [2];
    logic signed [PROD_W-1:0] r_prod [2];
    logic [CNT_BITS-1:0]      r_n;
    logic [IDX_W-1:0]         r_idx;
    logic [T_W-1:0]           r_t;
    logic [D_W-1:0]           r_rem;
    logic                     r_strobe;
    t_out_item                r_result;

    logic [CNT_BITS-1:0] n_sat;
    logic [CNT_BITS-1:0] n_minus1;
    logic [D_W-1:0]      den;
    logic [T_W-1:0]      div_quo;
    logic [D_W-1:0]      div_rem;
    logic                div_done;
    logic [D_W:0]        rem_sum;
    logic                rem_wrap;
    logic                last_pt;

    assign n_sat    = (i_item.point_count > CNT_BITS'(MAX_POINTS)) ?
                      CNT_BITS'(MAX_POINTS) : i_item.point_count;
    assign n_minus1 = r_n - CNT_BITS'(1);
    assign den      = n_minus1[D_W-1:0];
    assign last_pt  = (CNT_BITS'(r_idx) == n_minus1);

    cbz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_den   (den),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_done  (div_done)
    );

    // t advances by the quotient, with the remainder carried so that every
    // sample lands exactly on floor(i * 2^T_FRAC_BITS / d).
    assign rem_sum  = {1'b0, r_rem} + {1'b0, div_rem};
    assign rem_wrap = rem_sum >= {1'b0, den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_idx <= '0;
            r_t   <= '0;
            r_rem <= '0;
        end else if (i_cmd.load) begin
            r_n   <= n_sat;
            r_idx <= '0;
            r_t   <= '0;
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
            r_t   <= r_t + div_quo + T_W'(rem_wrap);
            r_rem <= rem_wrap ? D_W'(rem_sum - {1'b0, den}) : D_W'(rem_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_coef[0] <= make_coef(i_item.start_x, i_item.ctrl1_x,
                                   i_item.ctrl2_x, i_item.end_x);
            r_coef[1] <= make_coef(i_item.start_y, i_item.ctrl1_y,
                                   i_item.ctrl2_y, i_item.end_y);
        end
    end

    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
        logic signed [COEF_W-1:0] addend;

        always_comb begin
            case (i_cmd.sel)
                SEL_B:   addend = r_coef[ax].b;
                SEL_C:   addend = r_coef[ax].c;
                SEL_P0:  addend = r_coef[ax].p0;
                default: addend = r_coef[ax].p0;
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.mul) begin
                r_prod[ax] <= PROD_W'(r_acc[ax]) * $signed(PROD_W'(r_t));
            end
            if (i_cmd.init) begin
                r_acc[ax] <= to_acc(r_coef[ax].a);
            end else if (i_cmd.add) begin
                r_acc[ax] <= r_prod[ax][T_FRAC_BITS +: ACC_W] + to_acc(addend);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.curve_x    <= clamp_px(r_acc[0]);
            r_result.curve_y    <= clamp_px(r_acc[1]);
            r_result.last_point <= last_pt;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.n_zero   = (r_n == '0);
    assign o_stat.n_one    = (r_n == CNT_BITS'(1));
    assign o_stat.last_pt  = last_pt;
    assign o_strobe        = r_strobe;
    assign o_result        = r_result;

    // The stepper never runs past t = 1.0.
    a_t_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t <= T_ONE)
        else $error("t step ran past one");

    // The final sample of a multi-point segment is taken at exactly t = 1.0.
    a_last_at_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && last_pt && r_n > CNT_BITS'(1)) |-> (r_t == T_ONE))
        else $error("last sample not at t of one");

endmodule

// ----- hdl/cbz_ctrl.sv -----
// ----------------------------------------------------------------------------
// Cubic Bezier sampler controller
// Sequences segment load, step division and the per-point Horner steps.
// ----------------------------------------------------------------------------
module cbz_ctrl
    import cbz_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state    r_state, n_state;
    t_coef_sel r_stage, n_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= SEL_B;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.n_zero) begin
                    n_state = S_IDLE;
                end else if (i_stat.n_one) begin
                    n_state = S_INIT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:   if (i_stat.div_done) n_state = S_INIT;
            S_INIT:  n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = (r_stage == SEL_P0) ? S_EMIT : S_MUL;
            S_EMIT:  n_state = i_stat.last_pt ? S_IDLE : S_MUL;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_stage = r_stage;
        if (o_cmd.init) begin
            n_stage = SEL_B;
        end else if (o_cmd.add) begin
            case (r_stage)
                SEL_B:   n_stage = SEL_C;
                SEL_C:   n_stage = SEL_P0;
                default: n_stage = SEL_B;
            endcase
        end
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.sel = r_stage;
        case (r_state)
            S_IDLE:  o_cmd.load      = i_start;
            S_CHECK: o_cmd.div_start = !i_stat.n_zero && !i_stat.n_one;
            S_INIT:  o_cmd.init      = 1'b1;
            S_MUL:   o_cmd.mul       = 1'b1;
            S_ADD:   o_cmd.add       = 1'b1;
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.init = !i_stat.last_pt;
                o_cmd.step = !i_stat.last_pt;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // Every product is folded in by an add step in the following cycle.
    a_mul_then_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_ADD))
        else $error("multiply not followed by add");

    // A non-final point goes straight on to the next point's first multiply.
    a_emit_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_stat.last_pt) |=> (r_state == S_MUL))
        else $error("point sequence broken after emit");

endmodule
